// ===== hdl/tlpw_pkg.sv =====
// Shared types and constants for the two-level page walk access unit.
`timescale 1ns / 1ps
package tlpw_pkg;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_DIR  = 2'd1;
	localparam logic [1:0] ST_NO_TBL  = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;
	localparam logic       OP_READ    = 1'b0;
	localparam logic       OP_WRITE   = 1'b1;
	localparam logic       CFG_PAGING = 1'b0;
	localparam logic       CFG_DIR    = 1'b1;

	// Classified request handed from front to back.
	typedef struct packed {
		logic        wr;
		logic [31:0] va;
		logic [2:0]  cnt;
		logic [31:0] wdata;
		logic        skip;
		logic        split;
		logic [2:0]  len0;
	} req_t;

	// Completed access.
	typedef struct packed {
		logic [31:0] rdata;
		logic [1:0]  status;
	} rsp_t;
endpackage

// ===== hdl/tlpw_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
`timescale 1ns / 1ps
interface tlpw_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] virt_address;
	logic [2:0]  byte_count;
	logic [31:0] write_data;
	modport source (output valid, opcode, virt_address, byte_count, write_data, input ready);
	modport sink (input valid, opcode, virt_address, byte_count, write_data, output ready);
endinterface

interface tlpw_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [1:0]  status;
	modport source (output valid, read_data, status, input ready);
	modport sink (input valid, read_data, status, output ready);
endinterface

interface tlpw_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/tlpw_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tlpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/tlpw_front.sv =====
// Front end: takes requests, classifies page split and length, queues them.
`timescale 1ns / 1ps
module tlpw_front import tlpw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      paging,
	tlpw_req_if.sink  req,
	output logic      q_valid,
	input  logic      q_pop,
	output req_t      q_head
);
	req_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	req_t       cls;
	logic [2:0] n;
	logic [12:0] endo;
	logic        push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_head    = ent_q[rp_q];

	// Saturate count, detect page crossing
	always_comb begin
		n    = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
		endo = {1'b0, req.virt_address[11:0]} + {10'd0, n};
		cls.wr    = req.opcode;
		cls.va    = req.virt_address;
		cls.cnt   = n;
		cls.wdata = req.write_data;
		cls.skip  = (n == 3'd0);
		cls.split = paging && (endo > 13'd4096);
		cls.len0  = cls.split ? 3'(13'd4096 - {1'b0, req.virt_address[11:0]}) : n;
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cls.len0 <= cls.cnt) else $error("bad split length");
endmodule

// ===== hdl/tlpw_back.sv =====
// Back end: page walk, fault checks and byte accesses through one RAM port.
`timescale 1ns / 1ps
module tlpw_back import tlpw_pkg::*; #(
	parameter int STORE_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        paging,
	input  logic [19:0] dir_frame,
	input  logic        q_valid,
	output logic        q_pop,
	input  req_t        q_head,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);
	localparam int AW = STORE_ADDR_BITS;
	localparam logic [3:0] S_IDLE = 4'd0, S_DIR = 4'd1, S_DRD = 4'd2,
		S_TBL = 4'd3, S_TRD = 4'd4, S_CHK = 4'd5, S_DATA = 4'd6,
		S_DWAIT = 4'd7, S_RSP = 4'd8, S_DCHK = 4'd9;

	logic [3:0]  state_q;
	req_t        r_q;
	logic        seg_q;
	logic [1:0]  byte_q;
	logic [2:0]  k_q;
	logic [23:0] entry_q;
	logic [32:0] pa_q [2];
	logic [31:0] rd_q;
	logic [1:0]  st_q;
	logic [32:0] ent_addr_q;

	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [7:0]    ram_wd, ram_rd;
	logic [31:0]   seg_va;
	logic [2:0]    seg_len;
	logic [32:0]   daddr, taddr, pend, data_a;
	logic [1:0]    byte_seg_len;

	tlpw_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd));

	// Current segment address and length; the top entry byte comes straight from the RAM
	always_comb begin
		seg_va  = seg_q ? (r_q.va + {29'd0, r_q.len0}) : r_q.va;
		seg_len = seg_q ? (r_q.cnt - r_q.len0) : r_q.len0;
		daddr   = {1'b0, dir_frame, 12'd0} + {21'd0, seg_va[31:22], 2'd0};
		taddr   = {1'b0, ram_rd, entry_q[23:12], 12'd0} + {21'd0, seg_va[21:12], 2'd0};
		pend    = {1'b0, ram_rd, entry_q[23:12], seg_va[11:0]} + {30'd0, seg_len};
		data_a  = pa_q[k_q >= r_q.len0] +
			33'(k_q >= r_q.len0 ? k_q - r_q.len0 : k_q);
		byte_seg_len = 2'(r_q.cnt - 3'd1);
	end

	// RAM port select
	always_comb begin
		ram_we   = 1'b0;
		ram_wd   = r_q.wdata[8*k_q[1:0] +: 8];
		ram_addr = ent_addr_q[AW-1:0] + AW'(byte_q);
		if (state_q == S_DATA) begin
			ram_addr = data_a[AW-1:0];
			ram_we   = r_q.wr;
		end
	end

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign rsp_valid = (state_q == S_RSP);
	assign rsp.rdata  = rd_q;
	assign rsp.status = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					r_q    <= q_head;
					seg_q  <= 1'b0;
					k_q    <= 3'd0;
					rd_q   <= 32'd0;
					st_q   <= ST_OK;
					pa_q[0] <= {1'b0, q_head.va};
					if (q_head.skip)
						state_q <= S_RSP;
					else if (paging)
						state_q <= S_DIR;
					else
						state_q <= S_DCHK;
				end
			end
			S_DCHK: begin
				if ({1'b0, r_q.va} + {30'd0, r_q.cnt} > 33'(1) << AW) begin
					st_q <= ST_RANGE;
					state_q <= S_RSP;
				end else
					state_q <= S_DATA;
			end
			S_DIR: begin
				ent_addr_q <= daddr;
				byte_q <= 2'd0;
				if (daddr + 33'd4 > 33'(1) << AW) begin
					st_q <= ST_RANGE;
					state_q <= S_RSP;
				end else
					state_q <= S_DRD;
			end
			S_DRD, S_TRD: begin
				if (byte_q != 2'd0)
					entry_q[8*(byte_q-2'd1) +: 8] <= ram_rd;
				byte_q <= byte_q + 2'd1;
				if (byte_q == 2'd3)
					state_q <= (state_q == S_DRD) ? S_TBL : S_CHK;
			end
			S_TBL: begin
				if (!entry_q[0]) begin
					st_q <= ST_NO_DIR;
					state_q <= S_RSP;
				end else begin
					ent_addr_q <= taddr;
					byte_q <= 2'd0;
					if (taddr + 33'd4 > 33'(1) << AW) begin
						st_q <= ST_RANGE;
						state_q <= S_RSP;
					end else
						state_q <= S_TRD;
				end
			end
			S_CHK: begin
				if (!entry_q[0]) begin
					st_q <= ST_NO_TBL;
					state_q <= S_RSP;
				end else if (pend > 33'(1) << AW) begin
					st_q <= ST_RANGE;
					state_q <= S_RSP;
				end else begin
					pa_q[seg_q] <= pend - {30'd0, seg_len};
					if (r_q.split && !seg_q) begin
						seg_q <= 1'b1;
						state_q <= S_DIR;
					end else
						state_q <= S_DATA;
				end
			end
			S_DATA: begin
				state_q <= S_DWAIT;
			end
			S_DWAIT: begin
				if (!r_q.wr)
					rd_q[8*k_q[1:0] +: 8] <= ram_rd;
				k_q <= k_q + 3'd1;
				state_q <= (k_q[1:0] == byte_seg_len) ? S_RSP : S_DATA;
			end
			S_RSP: begin
				if (rsp_ready)
					state_q <= S_IDLE;
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && st_q != ST_OK |-> rd_q == 32'd0) else $error("fault with data");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> st_q == ST_OK) else $error("write on fault");
endmodule

// ===== hdl/two_level_page_walk_access.sv =====
// Top level: two-level page walk access unit.
// Throughput: one item at a time in the back end; up to two items wait in the queue.
// The single byte-wide RAM port sets the rate: entry bytes go one a cycle; each data byte takes S_DATA then S_DWAIT.
// Reset clears control and configuration; the store is undefined until written.
`timescale 1ns / 1ps
module two_level_page_walk_access import tlpw_pkg::*; #(
	parameter int STORE_ADDR_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tlpw_cfg_if.sink   cfg,
	tlpw_req_if.sink   req,
	tlpw_rsp_if.source rsp
);
	logic        paging_q;
	logic [19:0] dir_q;
	logic        q_valid, q_pop;
	req_t        q_head;
	rsp_t        r;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			dir_q    <= 20'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
			CFG_PAGING: paging_q <= cfg.data[0];
			CFG_DIR:    dir_q    <= cfg.data[19:0];
			default:    ;
			endcase
		end
	end

	tlpw_front u_front (.clk(clk), .arst_n(arst_n), .paging(paging_q), .req(req),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

	tlpw_back #(.STORE_ADDR_BITS(STORE_ADDR_BITS)) u_back (.clk(clk), .arst_n(arst_n),
		.paging(paging_q), .dir_frame(dir_q), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(r));

	assign rsp.read_data = r.rdata;
	assign rsp.status    = r.status;
endmodule

// ===== tb/tlpw_checker.sv =====
// Checker for the page walk access unit: predicts every access and compares the responses.
`timescale 1ns / 1ps
module tlpw_checker import tlpw_pkg::*; #(
	parameter int STORE_ADDR_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	tlpw_cfg_if  cfg,
	tlpw_req_if  req,
	tlpw_rsp_if  rsp,
	output int   errors,
	output int   pending
);
	localparam longint unsigned STORE_BYTES = 64'd1 << STORE_ADDR_BITS;

	// shadow of the physical store and the two registers
	logic [7:0]  shadow_mem [0:(1 << STORE_ADDR_BITS) - 1];
	logic        paging_en;
	logic [19:0] dir_frame;
	rsp_t        rsp_q [$];

	initial errors = 0;
	assign pending = rsp_q.size();

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [31:0] load_entry(input longint unsigned a);
		logic [31:0] v;
		for (int i = 0; i < 4; i++) begin
			v[8*i +: 8] = shadow_mem[int'((a + i) % STORE_BYTES)];
		end
		return v;
	endfunction

	// one translation: directory entry, table entry, then range of the data bytes
	function automatic logic [1:0] walk_page(input logic [31:0] va, input int n,
			output logic [31:0] pa);
		longint unsigned da;
		longint unsigned ta;
		longint unsigned pad;
		logic [31:0] pde;
		logic [31:0] pte;
		pa = '0;
		da = {32'h0, dir_frame, 12'h000} + 64'(va[31:22]) * 4;
		if (da + 4 > STORE_BYTES) return ST_RANGE;
		pde = load_entry(da);
		if (!pde[0]) return ST_NO_DIR;
		ta = {32'h0, pde[31:12], 12'h000} + 64'(va[21:12]) * 4;
		if (ta + 4 > STORE_BYTES) return ST_RANGE;
		pte = load_entry(ta);
		if (!pte[0]) return ST_NO_TBL;
		pad = {32'h0, pte[31:12], va[11:0]};
		if (pad + n > STORE_BYTES) return ST_RANGE;
		pa = pad[31:0];
		return ST_OK;
	endfunction

	task automatic predict_access(input logic op, input logic [31:0] va,
			input logic [2:0] cnt, input logic [31:0] wd);
		int n;
		int len0;
		int len1;
		int k;
		logic [31:0] pa0;
		logic [31:0] pa1;
		logic [31:0] a;
		logic [1:0]  st;
		rsp_t        e;
		n = (cnt > 4) ? 4 : int'(cnt);
		e = '0;
		pa0 = '0;
		pa1 = '0;
		len1 = 0;
		st = ST_OK;
		if (n != 0) begin
			if (!paging_en) begin
				if ({32'h0, va} + n > STORE_BYTES) st = ST_RANGE;
				pa0 = va;
				len0 = n;
			end else begin
				len0 = (int'(va[11:0]) + n > 4096) ? 4096 - int'(va[11:0]) : n;
				len1 = n - len0;
				st = walk_page(va, len0, pa0);
				if (st == ST_OK && len1 > 0) st = walk_page(va + len0, len1, pa1);
			end
			if (st != ST_OK) begin
				e.status = st;
			end else begin
				k = 0;
				for (int i = 0; i < len0 + len1; i++) begin
					a = (i < len0) ? pa0 + i : pa1 + (i - len0);
					a = a & (32'(STORE_BYTES) - 1);
					if (op == OP_WRITE) shadow_mem[a] = wd[8*k +: 8];
					else e.rdata[8*k +: 8] = shadow_mem[a];
					k++;
				end
			end
		end
		rsp_q.push_back(e);
	endtask

	// watch the channels; responses are matched before new requests are queued
	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			paging_en = 1'b0;
			dir_frame = '0;
			rsp_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.rdata = rsp.read_data;
				got.status = rsp.status;
				if (rsp_q.size() == 0) begin
					report($sformatf("response with nothing outstanding (%h/%0d)",
						got.rdata, got.status));
				end else begin
					want = rsp_q.pop_front();
					if (got.status !== want.status)
						report($sformatf("status %0d, predicted %0d", got.status, want.status));
					if (got.rdata !== want.rdata)
						report($sformatf("read_data %h, predicted %h", got.rdata, want.rdata));
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_PAGING) paging_en = cfg.data[0];
				else dir_frame = cfg.data[19:0];
			end
			if (req.valid && req.ready)
				predict_access(req.opcode, req.virt_address, req.byte_count, req.write_data);
		end
	end
endmodule

// ===== tb/tb_two_level_page_walk_access.sv =====
// Testbench top: drives configuration and accesses, stalls responses, gives the verdict.
`timescale 1ns / 1ps
module tb_two_level_page_walk_access;
	import tlpw_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   sent_n;
	int   burst_left;
	logic [19:0] dir_cur;
	bit   written [0:65535];

	tlpw_cfg_if cfg_if();
	tlpw_req_if req_if();
	tlpw_rsp_if rsp_if();

	two_level_page_walk_access #(.STORE_ADDR_BITS(16)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_if), .req(req_if), .rsp(rsp_if)
	);

	tlpw_checker #(.STORE_ADDR_BITS(16)) u_chk (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_if), .req(req_if), .rsp(rsp_if),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// response ready: changing pattern plus one long hold-off mid run
	initial begin
		int cyc;
		int mode;
		int hold_left;
		bit held;
		cyc = 0;
		mode = 0;
		hold_left = 0;
		held = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 2);
			if (!held && sent_n >= 700) begin
				held = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= 1'($urandom_range(0, 1));
					default: rsp_if.ready <= (cyc % 4 == 0);
				endcase
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// one request transfer, sent in bursts with random gaps
	task automatic send_access(input logic op, input logic [31:0] va,
			input logic [2:0] cnt, input logic [31:0] wd);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		req_if.valid <= 1'b1;
		req_if.opcode <= op;
		req_if.virt_address <= va;
		req_if.byte_count <= cnt;
		req_if.write_data <= wd;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		sent_n++;
	endtask

	task automatic put_word(input logic [31:0] addr, input logic [31:0] val);
		for (int i = 0; i < 4; i++) written[addr + i] = 1;
		send_access(OP_WRITE, addr, 3'd4, val);
	endtask

	// let everything outstanding drain before touching the registers
	task automatic settle();
		req_if.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// frame that the page tables built below map a virtual page to, -1 on a fault
	function automatic int vpn_frame(input logic [19:0] vpn);
		if (dir_cur == 20'hfffff) return -1;
		if (vpn[19:10] == 10'd0) begin
			case (vpn[9:0])
				10'd0: return 8;
				10'd1: return 9;
				10'h3ff: return 10;
				default: return -1;
			endcase
		end
		if (vpn[19:10] == 10'h3ff) begin
			case (vpn[9:0])
				10'd0: return 11;
				10'd2: return 13;
				10'd3: return 14;
				10'h3ff: return 12;
				default: return -1;
			endcase
		end
		return -1;
	endfunction

	// random access; reads are only aimed at bytes already written
	task automatic random_access(input bit paged);
		logic        op;
		logic [31:0] va;
		logic [31:0] a;
		logic [31:0] pa [4];
		logic [11:0] off;
		logic [9:0]  d;
		logic [9:0]  t;
		int r;
		int n;
		int nb;
		int f;
		bit ok;
		op = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		n = (r < 2) ? 0 : (r < 4) ? $urandom_range(5, 7) : $urandom_range(1, 4);
		if (paged && dir_cur == 20'hfffff) begin
			va = $urandom;
		end else if (paged) begin
			case ($urandom_range(0, 3))
				0: d = 10'd0;
				1: d = 10'd1;
				2: d = 10'd2;
				default: d = 10'h3ff;
			endcase
			if ($urandom_range(0, 3) != 0) d = ($urandom_range(0, 1) != 0) ? 10'd0 : 10'h3ff;
			case ($urandom_range(0, 4))
				0: t = 10'd0;
				1: t = 10'd1;
				2: t = 10'd2;
				3: t = 10'd3;
				default: t = 10'h3ff;
			endcase
			r = $urandom_range(0, 9);
			if (r < 5) off = 12'hffc + 12'($urandom_range(0, 3));
			else if (r < 9) off = 12'($urandom_range(0, 31));
			else off = 12'($urandom);
			va = {d, t, off};
		end else begin
			r = $urandom_range(0, 19);
			if (r < 17) va = 32'h4000 + $urandom_range(0, 32'hbfff);
			else if (r < 18) va = 32'hfffc + $urandom_range(0, 3);
			else va = $urandom;
			if (va < 32'h4000) va = va + 32'h4000;
		end
		nb = (n > 4) ? 4 : n;
		ok = 1;
		for (int i = 0; i < nb; i++) begin
			a = va + i;
			if (paged) begin
				f = vpn_frame(a[31:12]);
				if (f < 0) ok = 0;
				else pa[i] = {f[19:0], a[11:0]};
			end else begin
				if ({32'h0, va} + i >= 64'h10000) ok = 0;
				else pa[i] = a;
			end
		end
		if (ok && op == OP_READ) begin
			for (int i = 0; i < nb; i++) if (!written[pa[i][15:0]]) op = OP_WRITE;
		end
		if (ok && op == OP_WRITE) begin
			for (int i = 0; i < nb; i++) written[pa[i][15:0]] = 1;
		end
		send_access(op, va, 3'(n), $urandom);
	endtask

	task automatic build_directory(input logic [31:0] base);
		put_word(base + 32'h0, 32'h0000_2001);
		put_word(base + 32'h4, 32'h1234_5ffe);
		put_word(base + 32'h8, 32'h0002_0001);
		put_word(base + 32'hffc, 32'h0000_3001);
	endtask

	task automatic run_random(input int count, input bit paged);
		repeat (count) random_access(paged);
	endtask

	initial begin
		sent_n = 0;
		burst_left = 0;
		dir_cur = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_PAGING;
		cfg_if.data = '0;
		req_if.valid = 1'b0;
		req_if.opcode = OP_READ;
		req_if.virt_address = '0;
		req_if.byte_count = 3'd1;
		req_if.write_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// physical mode: build directories and tables, then the edge cases
		write_reg(CFG_PAGING, 32'h0);
		write_reg(CFG_DIR, 32'h0);
		build_directory(32'h1000);
		build_directory(32'h0000);
		put_word(32'h2000, 32'h0000_8001);
		put_word(32'h2004, 32'h0000_9ff1);
		put_word(32'h2008, 32'haaaa_a000);
		put_word(32'h200c, 32'h0010_0001);
		put_word(32'h2010, 32'h0000_0000);
		put_word(32'h2ffc, 32'h0000_a001);
		put_word(32'h3000, 32'h0000_b001);
		put_word(32'h3004, 32'h0000_0000);
		put_word(32'h3008, 32'h0000_d001);
		put_word(32'h300c, 32'h0000_e001);
		put_word(32'h3010, 32'h0000_0000);
		put_word(32'h3ffc, 32'h0000_c001);
		send_access(OP_READ, 32'h2004, 3'd4, 32'h0);
		send_access(OP_WRITE, 32'h5000, 3'd0, 32'hffff_ffff);
		send_access(OP_WRITE, 32'h5000, 3'd7, 32'hdead_beef);
		for (int i = 0; i < 4; i++) written[32'h5000 + i] = 1;
		send_access(OP_READ, 32'h5000, 3'd7, 32'h0);
		send_access(OP_WRITE, 32'h0000_ffff, 3'd2, 32'h1111_1111);
		send_access(OP_READ, 32'hffff_ffff, 3'd4, 32'h0);
		send_access(OP_READ, 32'h0001_0000, 3'd1, 32'h0);
		send_access(OP_WRITE, 32'h0000_ffff, 3'd1, 32'h0000_00a5);
		written[16'hffff] = 1;
		send_access(OP_READ, 32'h0000_ffff, 3'd1, 32'h0);
		run_random(250, 0);
		settle();

		// paging through the directory at frame 1
		write_reg(CFG_PAGING, 32'h1);
		write_reg(CFG_DIR, 32'h1);
		dir_cur = 20'h1;
		send_access(OP_WRITE, 32'hffff_fffe, 3'd4, 32'h8765_4321);
		written[16'hcffe] = 1;
		written[16'hcfff] = 1;
		written[16'h8000] = 1;
		written[16'h8001] = 1;
		send_access(OP_READ, 32'hffff_fffe, 3'd4, 32'h0);
		send_access(OP_READ, 32'h003f_fffe, 3'd4, 32'h0);
		send_access(OP_READ, 32'h0080_0000, 3'd1, 32'h0);
		send_access(OP_READ, 32'h0000_2000, 3'd1, 32'h0);
		send_access(OP_READ, 32'h0000_3000, 3'd1, 32'h0);
		run_random(550, 1);
		settle();

		// directory beyond the store: every walk faults
		write_reg(CFG_DIR, 32'hfffff);
		dir_cur = 20'hfffff;
		run_random(40, 1);
		settle();

		// directory at frame 0
		write_reg(CFG_DIR, 32'h0);
		dir_cur = 20'h0;
		run_random(200, 1);
		settle();

		// back to physical mode
		write_reg(CFG_PAGING, 32'h0);
		run_random(150, 0);
		settle();

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
